// ===== design/nwid_pkg.sv =====
`default_nettype none

package nwid_pkg;

  localparam int ENTRIES   = 1024;
  localparam int KEY_BYTES = 64;

  localparam int ENT_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int KLW    = $clog2(KEY_BYTES);
  localparam int KEY_AW = ENT_AW + KLW;
  localparam int ID_W   = 16;
  localparam int CHAR_W = 8;
  localparam int OP_W   = 2;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_D0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_D9     = 8'h39;

  localparam logic [KLW-1:0] KEY_MAX = KLW'(KEY_BYTES - 1);

  typedef struct packed {
    logic              key_we;
    logic [KEY_AW-1:0] key_addr;
    logic [CHAR_W-1:0] key_byte;
    logic              meta_we;
    logic [ENT_AW-1:0] meta_addr;
    logic [KLW-1:0]    meta_len;
    logic [ID_W-1:0]   meta_id;
    logic              q_we;
    logic [KLW-1:0]    q_addr;
    logic [CHAR_W-1:0] q_byte;
    logic              search;
    logic [KLW-1:0]    trim_len;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  function automatic logic is_trim(input logic [CHAR_W-1:0] c);
    is_trim = (c == CH_APOS) || (c == CH_HYPHEN);
  endfunction

  function automatic logic is_kept(input logic [CHAR_W-1:0] c);
    is_kept = (c >= CH_LA && c <= CH_LZ) || (c >= CH_D0 && c <= CH_D9) || is_trim(c);
  endfunction

endpackage

`default_nettype wire

// ===== design/normalized_word_id_lookup.sv =====
// Word-to-ID dictionary with exact-match lookup.
// Input queue (push/full): opcode 0 appends a table character (entry_id taken
// with last), opcode 1 streams a query character, opcode 2 clears the table.
// A transaction is taken when push is high and full is low.
// Result queue (empty/pop): one result per query word, given on its last
// character: word_id and matched, oldest first, held until popped.
// The front part accepts one input transaction per cycle and queues work for
// the search engine; it only stalls when its 4-deep command queue fills.
// The search time for a query grows with the entries scanned and the key bytes
// compared: the engine scans one entry at a time, reads each entry's metadata,
// then compares key bytes through the registered key memory read.
// The worst case is a full table of 63-character keys that differ from the
// query only in the last byte.
// Reset empties the table and both queues; key memory needs no clearing.
// While pop is held low the result queue fills (two results), then the search
// engine waits, the command queue fills and full rises.
`default_nettype none

module normalized_word_id_lookup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  char_byte,
  input  wire logic [15:0] entry_id,
  input  wire logic        last,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      word_id,
  output logic             matched
);
  import nwid_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_valid;

  nwid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .opcode    (opcode),
    .char_byte (char_byte),
    .entry_id  (entry_id),
    .last      (last),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  nwid_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .rd_data (cmd_out),
    .valid   (cmd_valid)
  );

  nwid_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .word_id   (word_id),
    .matched   (matched)
  );

endmodule

`default_nettype wire

// ===== design/nwid_front.sv =====
`default_nettype none

module nwid_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [1:0]            opcode,
  input  wire logic [7:0]            char_byte,
  input  wire logic [15:0]           entry_id,
  input  wire logic                  last,
  output logic                       full,
  output logic                       cmd_push,
  output nwid_pkg::cmd_t             cmd,
  input  wire logic                  cmd_full
);
  import nwid_pkg::*;

  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [KLW-1:0]   load_pos, load_pos_next;
  logic [KLW-1:0]   key_len, key_len_next;
  logic             zero_seen, zero_seen_next;
  logic [KLW-1:0]   query_len, query_len_next;
  logic [KLW-1:0]   trim_len, trim_len_next;
  logic             stopped, stopped_next;

  logic             accept;
  logic             stored;
  logic [KLW-1:0]   len_cur;
  logic [CHAR_W-1:0] folded;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  always_comb begin
    entry_count_next = entry_count;
    load_pos_next    = load_pos;
    key_len_next     = key_len;
    zero_seen_next   = zero_seen;
    query_len_next   = query_len;
    trim_len_next    = trim_len;
    stopped_next     = stopped;
    cmd              = '0;
    cmd_push         = 1'b0;
    stored           = load_pos < KEY_MAX;
    len_cur          = key_len + KLW'(stored && !zero_seen && (char_byte != '0));
    folded           = (char_byte >= CH_UA && char_byte <= CH_UZ) ?
                       char_byte + (CH_LA - CH_UA) : char_byte;
    if (accept) begin
      case (opcode)
        OP_LOAD: begin
          if (entry_count != CNT_W'(ENTRIES)) begin
            cmd_push     = 1'b1;
            cmd.key_we   = stored;
            cmd.key_addr = {entry_count[ENT_AW-1:0], load_pos};
            cmd.key_byte = char_byte;
            if (last) begin
              cmd.meta_we      = 1'b1;
              cmd.meta_addr    = entry_count[ENT_AW-1:0];
              cmd.meta_len     = len_cur;
              cmd.meta_id      = entry_id;
              entry_count_next = entry_count + 1'b1;
              load_pos_next    = '0;
              key_len_next     = '0;
              zero_seen_next   = 1'b0;
            end else begin
              load_pos_next  = load_pos + KLW'(stored);
              key_len_next   = len_cur;
              zero_seen_next = zero_seen || (stored && (char_byte == '0));
            end
          end
        end
        OP_QUERY: begin
          if (!stopped) begin
            if (char_byte == '0) begin
              stopped_next = 1'b1;
            end else if (is_kept(folded) && query_len < KEY_MAX) begin
              cmd.q_we       = 1'b1;
              cmd.q_addr     = query_len;
              cmd.q_byte     = folded;
              query_len_next = query_len + 1'b1;
              if (!is_trim(folded)) begin
                trim_len_next = query_len + 1'b1;
              end
            end
          end
          cmd_push = cmd.q_we || last;
          if (last) begin
            cmd.search     = 1'b1;
            cmd.trim_len   = trim_len_next;
            cmd.count      = entry_count;
            query_len_next = '0;
            trim_len_next  = '0;
            stopped_next   = 1'b0;
          end
        end
        OP_CLEAR: begin
          entry_count_next = '0;
          load_pos_next    = '0;
          key_len_next     = '0;
          zero_seen_next   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      load_pos    <= '0;
      key_len     <= '0;
      zero_seen   <= 1'b0;
      query_len   <= '0;
      trim_len    <= '0;
      stopped     <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      load_pos    <= load_pos_next;
      key_len     <= key_len_next;
      zero_seen   <= zero_seen_next;
      query_len   <= query_len_next;
      trim_len    <= trim_len_next;
      stopped     <= stopped_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/nwid_cmdq.sv =====
`default_nettype none

module nwid_cmdq (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  wire nwid_pkg::cmd_t wr_data,
  output logic          full,
  input  wire logic     rd,
  output nwid_pkg::cmd_t rd_data,
  output logic          valid
);
  import nwid_pkg::*;

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr;
  logic [CMDQ_AW-1:0] rptr;
  logic [CMDQ_AW:0]   fill;
  logic               do_wr;
  logic               do_rd;

  assign full    = fill == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign valid   = fill != '0;
  assign rd_data = slots[rptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      fill <= fill + (CMDQ_AW+1)'(do_wr) - (CMDQ_AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/nwid_back.sv =====
`default_nettype none

module nwid_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire nwid_pkg::cmd_t cmd,
  input  wire logic         cmd_valid,
  output logic              cmd_pop,
  output logic              empty,
  input  wire logic         pop,
  output logic [15:0]       word_id,
  output logic              matched
);
  import nwid_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MREAD = 6'b000010,
    S_MCHK  = 6'b000100,
    S_BREAD = 6'b001000,
    S_BCHK  = 6'b010000,
    S_RES   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [KLW-1:0]  len;
    logic [ID_W-1:0] id;
  } meta_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            hit;
  } res_t;

  logic [CHAR_W-1:0] key_mem  [ENTRIES * KEY_BYTES];
  meta_t             meta_mem [ENTRIES];
  logic [CHAR_W-1:0] q_mem    [KEY_BYTES];

  logic [CHAR_W-1:0] key_rd;
  logic [CHAR_W-1:0] q_rd;
  meta_t             meta_rd;

  state_t           state, state_next;
  logic [CNT_W-1:0] ent, ent_next;
  logic [KLW-1:0]   byt, byt_next;
  logic [KLW-1:0]   tl, tl_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  res_t             res, res_next;
  logic             res_push;

  res_t       rq [2];
  logic       rq_w;
  logic       rq_r;
  logic [1:0] rq_cnt;
  logic       res_full;
  logic       res_pop;

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign res_full = rq_cnt == 2'd2;
  assign res_push = (state == S_RES) && !res_full;

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.key_we) begin
      key_mem[cmd.key_addr] <= cmd.key_byte;
    end
    key_rd <= key_mem[{ent[ENT_AW-1:0], byt}];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.meta_we) begin
      meta_mem[cmd.meta_addr] <= '{len: cmd.meta_len, id: cmd.meta_id};
    end
    meta_rd <= meta_mem[ent[ENT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.q_we) begin
      q_mem[cmd.q_addr] <= cmd.q_byte;
    end
    q_rd <= q_mem[byt];
  end

  always_comb begin
    state_next = state;
    ent_next   = ent;
    byt_next   = byt;
    tl_next    = tl;
    cnt_next   = cnt;
    res_next   = res;
    case (state)
      S_IDLE: begin
        if (cmd_pop && cmd.search) begin
          tl_next  = cmd.trim_len;
          cnt_next = cmd.count;
          ent_next = '0;
          byt_next = '0;
          res_next = '0;
          if (cmd.trim_len == '0 || cmd.count == '0) begin
            state_next = S_RES;
          end else begin
            state_next = S_MREAD;
          end
        end
      end
      S_MREAD: begin
        state_next = S_MCHK;
      end
      S_MCHK: begin
        if (meta_rd.len == tl) begin
          byt_next   = '0;
          state_next = S_BREAD;
        end else if (ent + 1'b1 == cnt) begin
          state_next = S_RES;
        end else begin
          ent_next   = ent + 1'b1;
          state_next = S_MREAD;
        end
      end
      S_BREAD: begin
        state_next = S_BCHK;
      end
      S_BCHK: begin
        if (key_rd == q_rd && KLW'(byt + 1'b1) == tl) begin
          res_next   = '{id: meta_rd.id, hit: 1'b1};
          state_next = S_RES;
        end else if (key_rd == q_rd) begin
          byt_next   = byt + 1'b1;
          state_next = S_BREAD;
        end else if (ent + 1'b1 == cnt) begin
          state_next = S_RES;
        end else begin
          ent_next   = ent + 1'b1;
          state_next = S_MREAD;
        end
      end
      S_RES: begin
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    ent <= ent_next;
    byt <= byt_next;
    tl  <= tl_next;
    cnt <= cnt_next;
    res <= res_next;
  end

  // result queue, two deep
  assign empty   = rq_cnt == 2'd0;
  assign res_pop = pop && !empty;
  assign word_id = rq[rq_r].id;
  assign matched = rq[rq_r].hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_w   <= 1'b0;
      rq_r   <= 1'b0;
      rq_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        rq_w <= !rq_w;
      end
      if (res_pop) begin
        rq_r <= !rq_r;
      end
      rq_cnt <= rq_cnt + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_w] <= res;
    end
  end

  a_rq_bound: assert property (@(posedge clk) disable iff (rst) rq_cnt != 2'd3)
    else $error("result queue overfilled");
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BCHK) |-> (byt < tl))
    else $error("byte index past query length");
  a_ent_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MREAD || state == S_MCHK || state == S_BREAD || state == S_BCHK)
    |-> (ent < cnt))
    else $error("entry index past table count");
  a_hit_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && res.hit) |-> (tl != '0))
    else $error("hit reported for empty word");

endmodule

`default_nettype wire

// ===== tb/sv/tb_normalized_word_id_lookup.sv =====
`timescale 1ns / 1ps

module tb_normalized_word_id_lookup;
  import nwid_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int VOCAB_N = 24;
  localparam int WORD_MAX = KEY_BYTES + 8;
  localparam int ITEM_GOAL = 1800;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AT_A = 40;
  localparam int HOLD_AT_B = 120;
  localparam int DRAIN_CYCLES = 500;
  localparam int REPORT_MAX = 50;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ID_W-1:0]   id;
    logic              fin;
  } char_txn_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            hit;
  } id_answer_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [1:0]        opcode = '0;
  logic [7:0]        char_byte = '0;
  logic [15:0]       entry_id = '0;
  logic              last = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [15:0]       word_id;
  logic              matched;

  normalized_word_id_lookup dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .opcode(opcode),
    .char_byte(char_byte),
    .entry_id(entry_id),
    .last(last),
    .empty(empty),
    .pop(pop),
    .word_id(word_id),
    .matched(matched)
  );

  always #10 clk = ~clk;

  // dictionary shadow state
  logic [CHAR_W-1:0] tbl_key [0:ENTRIES-1][0:KEY_BYTES-1];
  int                tbl_len [0:ENTRIES-1];
  logic [ID_W-1:0]   tbl_id  [0:ENTRIES-1];
  int                n_entries = 0;
  int                load_pos = 0;
  logic [CHAR_W-1:0] qbuf [0:KEY_BYTES-1];
  int                q_len = 0;
  int                q_trim = 0;
  bit                q_halt = 1'b0;

  id_answer_t        id_answers [$];
  char_txn_t         feed_q [$];
  char_txn_t         cur_item;
  logic [CHAR_W-1:0] scratch [$];
  logic [CHAR_W-1:0] vocab_ch [0:VOCAB_N-1][0:WORD_MAX-1];
  int                vocab_len [0:VOCAB_N-1];

  int n_total = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_errors = 0;
  bit taken = 1'b0;
  bit got_one = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int tx_calm = 0;
  int rx_calm = 0;

  function automatic bit char_punct(input logic [CHAR_W-1:0] c);
    return c == CH_APOS || c == CH_HYPHEN;
  endfunction

  function automatic bit char_kept(input logic [CHAR_W-1:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_D0 && c <= CH_D9) || char_punct(c);
  endfunction

  task automatic dict_apply(input char_txn_t t);
    int i, j, klen;
    bit same;
    logic [CHAR_W-1:0] c;
    id_answer_t a;
    case (t.op)
      OP_LOAD: begin
        if (n_entries < ENTRIES) begin
          if (load_pos < KEY_BYTES - 1) begin
            tbl_key[n_entries][load_pos] = t.ch;
            load_pos++;
          end
          if (t.fin) begin
            klen = 0;
            while (klen < load_pos && tbl_key[n_entries][klen] != 8'h00) klen++;
            tbl_len[n_entries] = klen;
            tbl_id[n_entries] = t.id;
            n_entries++;
            load_pos = 0;
          end
        end
      end
      OP_CLEAR: begin
        n_entries = 0;
        load_pos = 0;
      end
      OP_QUERY: begin
        c = t.ch;
        if (!q_halt) begin
          if (c == 8'h00) begin
            q_halt = 1'b1;
          end else begin
            if (c >= CH_UA && c <= CH_UZ) c = c + (CH_LA - CH_UA);
            if (char_kept(c) && q_len < KEY_BYTES - 1) begin
              qbuf[q_len] = c;
              q_len++;
              if (!char_punct(c)) q_trim = q_len;
            end
          end
        end
        if (t.fin) begin
          a.id = '0;
          a.hit = 1'b0;
          if (q_trim != 0) begin
            for (i = 0; i < n_entries && !a.hit; i++) begin
              if (tbl_len[i] == q_trim) begin
                same = 1'b1;
                for (j = 0; j < q_trim; j++) if (tbl_key[i][j] != qbuf[j]) same = 1'b0;
                if (same) begin
                  a.id = tbl_id[i];
                  a.hit = 1'b1;
                end
              end
            end
          end
          id_answers.push_back(a);
          q_len = 0;
          q_trim = 0;
          q_halt = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= REPORT_MAX)
      $display("mismatch on %s at result %0d: got %0h want %0h", what, n_results, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return ID_W'($urandom);
  endfunction

  function automatic logic [CHAR_W-1:0] kept_char(input bit punct_ok);
    int r;
    r = $urandom_range(0, 99);
    if (punct_ok && r < 6) return r[0] ? CH_APOS : CH_HYPHEN;
    if (r < 20) return CH_D0 + CHAR_W'($urandom_range(0, 9));
    return CH_LA + CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] junk_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255));
    while (char_kept(c) || (c >= CH_UA && c <= CH_UZ));
    return c;
  endfunction

  task automatic put(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                     input logic [ID_W-1:0] id, input logic fin);
    char_txn_t t;
    t.op = op;
    t.ch = ch;
    t.id = id;
    t.fin = fin;
    feed_q.push_back(t);
    n_total++;
  endtask

  task automatic emit(input logic [OP_W-1:0] op, input int from, input int upto,
                      input logic [ID_W-1:0] id, input bit close);
    int i;
    for (i = from; i < upto; i++)
      put(op, scratch[i], (close && i == upto - 1) ? id : ID_W'($urandom),
          close && i == upto - 1);
  endtask

  task automatic make_word();
    int n, i, r;
    scratch.delete();
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(1, 8);
    else if (r < 94) n = $urandom_range(9, 24);
    else n = $urandom_range(KEY_BYTES - 4, WORD_MAX - 2);
    for (i = 0; i < n; i++) scratch.push_back(kept_char(i < n - 1 || $urandom_range(0, 9) == 0));
  endtask

  task automatic store_vocab(input int k);
    int i;
    make_word();
    vocab_len[k] = scratch.size();
    for (i = 0; i < scratch.size(); i++) vocab_ch[k][i] = scratch[i];
  endtask

  task automatic build_load(input int k);
    int i, r, p;
    scratch.delete();
    r = $urandom_range(0, 99);
    if (r < 3) begin
      p = $urandom_range(1, 12);
      for (i = 0; i < p; i++) scratch.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      for (i = 0; i < vocab_len[k]; i++) scratch.push_back(vocab_ch[k][i]);
      p = $urandom_range(0, scratch.size() - 1);
      if (r < 11) begin
        scratch[p] = 8'h00;
      end else if (r < 15) begin
        scratch[0] = 8'h00;
      end else if (r < 22 && scratch[p] >= CH_LA && scratch[p] <= CH_LZ) begin
        scratch[p] = scratch[p] - (CH_LA - CH_UA);
      end
    end
  endtask

  task automatic build_query(input int k);
    int i, r, n;
    bit noisy, caps;
    logic [CHAR_W-1:0] c;
    scratch.delete();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) scratch.push_back(CHAR_W'($urandom_range(0, 255)));
    end else if (r < 9) begin
      case ($urandom_range(0, 2))
        0: scratch.push_back(8'h00);
        1: scratch.push_back(junk_char());
        default: scratch.push_back(kept_char(1'b1) == CH_APOS ? CH_APOS : CH_HYPHEN);
      endcase
    end else begin
      if (r < 15) begin
        make_word();
      end else begin
        noisy = $urandom_range(0, 6) == 0;
        caps = $urandom_range(0, 1) == 1;
        for (i = 0; i < vocab_len[k]; i++) begin
          c = vocab_ch[k][i];
          if (noisy && $urandom_range(0, 3) == 0) scratch.push_back(junk_char());
          if (caps && c >= CH_LA && c <= CH_LZ && $urandom_range(0, 1)) c = c - (CH_LA - CH_UA);
          scratch.push_back(c);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) scratch.push_back($urandom_range(0, 1) ? CH_APOS : CH_HYPHEN);
      end
      if ($urandom_range(0, 11) == 0) begin
        scratch.push_back(8'h00);
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) scratch.push_back(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // transaction accepted by the block
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      dict_apply(cur_item);
      n_taken++;
      taken = 1'b1;
    end
  end

  always @(negedge clk) begin : sender
    logic nxt;
    nxt = push;
    if (rst) begin
      nxt = 1'b0;
    end else if (!push || taken) begin
      nxt = 1'b0;
      if (taken) begin
        taken = 1'b0;
        if (tx_calm > 0) begin
          tx_calm--;
          gap_left = 0;
        end else begin
          gap_left = pick_gap();
          if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(20, 80);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (feed_q.size() != 0) begin
        cur_item = feed_q.pop_front();
        opcode <= cur_item.op;
        char_byte <= cur_item.ch;
        entry_id <= cur_item.id;
        last <= cur_item.fin;
        nxt = 1'b1;
      end
    end
    push <= nxt;
  end

  always @(posedge clk) begin : monitor
    id_answer_t a;
    if (!rst && pop && !empty) begin
      n_results++;
      got_one = 1'b1;
      if (id_answers.size() == 0) begin
        report("unexpected result", int'(word_id), 0);
      end else begin
        a = id_answers.pop_front();
        if (word_id !== a.id) report("word_id", int'(word_id), int'(a.id));
        if (matched !== a.hit) report("matched", int'(matched), int'(a.hit));
      end
    end
  end

  // long hold-offs let the result and command queues fill so full rises
  always @(negedge clk) begin : receiver
    logic nxt;
    nxt = 1'b0;
    if (!rst) begin
      if (got_one) begin
        got_one = 1'b0;
        if (n_results == HOLD_AT_A || n_results == HOLD_AT_B) begin
          stall_left = HOLD_CYCLES;
        end else if (rx_calm > 0) begin
          rx_calm--;
          stall_left = 0;
        end else begin
          stall_left = pick_gap();
          if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(20, 60);
        end
      end
      if (stall_left > 0) stall_left--;
      else nxt = 1'b1;
    end
    pop <= nxt;
  end

  initial begin
    #60_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int i, k, r, goal, cut, words_in;
    logic [CHAR_W-1:0] held [$];

    for (k = 0; k < VOCAB_N; k++) store_vocab(k);

    // directed: "ab" with max ID, "a" with ID 0, key cut at a zero, empty key
    put(OP_LOAD, CH_LA, 16'h0001, 1'b0);
    put(OP_LOAD, CH_LA + 8'd1, 16'hFFFF, 1'b1);
    put(OP_LOAD, CH_LA, 16'h0000, 1'b1);
    put(OP_LOAD, CH_LA + 8'd2, 16'h5555, 1'b0);
    put(OP_LOAD, 8'h00, 16'hAAAA, 1'b0);
    put(OP_LOAD, CH_LA + 8'd23, 16'h0007, 1'b1);
    put(OP_LOAD, 8'h00, 16'h0009, 1'b1);
    // upper case folded, 0xFF dropped
    put(OP_QUERY, CH_UA, 16'h0000, 1'b0);
    put(OP_QUERY, 8'hFF, 16'hFFFF, 1'b0);
    put(OP_QUERY, CH_UA + 8'd1, 16'h0000, 1'b1);
    // trailing punctuation trimmed, hits the ID 0 entry
    put(OP_QUERY, CH_LA, 16'h0000, 1'b0);
    put(OP_QUERY, CH_APOS, 16'h0000, 1'b0);
    put(OP_QUERY, CH_HYPHEN, 16'h0000, 1'b1);
    // characters after a zero byte ignored
    put(OP_QUERY, CH_UA + 8'd2, 16'h0000, 1'b0);
    put(OP_QUERY, 8'h00, 16'h0000, 1'b0);
    put(OP_QUERY, CH_LA + 8'd16, 16'h0000, 1'b1);
    put(OP_QUERY, 8'h00, 16'h0000, 1'b1);
    put(OP_QUERY, CH_HYPHEN, 16'h0000, 1'b1);
    put(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
    put(OP_CLEAR, 8'h00, 16'h0000, 1'b0);
    put(OP_QUERY, CH_D0, 16'h0000, 1'b0);
    put(OP_QUERY, CH_D9, 16'h0000, 1'b1);

    // full table: last slot hit, loads past the end dropped
    put(OP_CLEAR, 8'h00, 16'h0000, 1'b0);
    for (i = 0; i < ENTRIES - 2; i++) put(OP_LOAD, CH_LA + CHAR_W'(i % 26), ID_W'(i + 1), 1'b1);
    put(OP_LOAD, CH_LA + 8'd23, 16'h0000, 1'b0);
    put(OP_LOAD, CH_D9, 16'h1234, 1'b1);
    put(OP_LOAD, CH_LA + 8'd24, 16'h0000, 1'b0);
    put(OP_LOAD, CH_LA + 8'd24, 16'hBEEF, 1'b1);
    put(OP_LOAD, CH_LA + 8'd25, 16'h0000, 1'b0);
    put(OP_LOAD, CH_LA + 8'd25, 16'h4321, 1'b1);
    put(OP_LOAD, CH_LA + 8'd25, 16'h0000, 1'b0);
    put(OP_QUERY, CH_UA + 8'd24, 16'h0000, 1'b0);
    put(OP_QUERY, CH_LA + 8'd24, 16'h0000, 1'b1);
    put(OP_QUERY, CH_LA + 8'd25, 16'h0000, 1'b0);
    put(OP_QUERY, CH_LA + 8'd25, 16'h0000, 1'b1);
    put(OP_QUERY, CH_LA, 16'h0000, 1'b1);
    put(OP_QUERY, CH_UA + 8'd23, 16'h0000, 1'b0);
    put(OP_QUERY, CH_D9, 16'h0000, 1'b1);
    put(OP_CLEAR, 8'h00, 16'h0000, 1'b0);
    put(OP_QUERY, CH_LA, 16'h0000, 1'b1);

    words_in = 0;
    goal = ITEM_GOAL;
    while (n_total < goal) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, VOCAB_N - 1);
      if (r < 3) begin
        put(OP_UNUSED, CHAR_W'($urandom), ID_W'($urandom), 1'($urandom_range(0, 1)));
      end else if (r < 6 || (r < 30 && words_in > 40)) begin
        put(OP_CLEAR, CHAR_W'($urandom), ID_W'($urandom), 1'($urandom_range(0, 1)));
        words_in = 0;
        for (i = 0; i < 6; i++) store_vocab($urandom_range(0, VOCAB_N - 1));
      end else if (r < 36) begin
        build_load(k);
        emit(OP_LOAD, 0, scratch.size(), pick_id(), 1'b1);
        words_in++;
      end else if (r < 39) begin
        // partial load abandoned by a clear
        build_load(k);
        emit(OP_LOAD, 0, $urandom_range(1, scratch.size()), '0, 1'b0);
        put(OP_CLEAR, CHAR_W'($urandom), ID_W'($urandom), 1'($urandom_range(0, 1)));
        words_in = 0;
      end else if (r < 45) begin
        // query word interrupted by a load or a clear
        build_query(k);
        held = scratch;
        cut = $urandom_range(0, held.size() - 1);
        emit(OP_QUERY, 0, cut, '0, 1'b0);
        if ($urandom_range(0, 2) != 0) begin
          build_load($urandom_range(0, VOCAB_N - 1));
          emit(OP_LOAD, 0, scratch.size(), pick_id(), 1'b1);
          words_in++;
        end else begin
          put(OP_CLEAR, CHAR_W'($urandom), ID_W'($urandom), 1'($urandom_range(0, 1)));
          words_in = 0;
        end
        scratch = held;
        emit(OP_QUERY, cut, scratch.size(), ID_W'($urandom), 1'b1);
      end else begin
        build_query(k);
        emit(OP_QUERY, 0, scratch.size(), ID_W'($urandom), 1'b1);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_taken < n_total) @(posedge clk);
    while (id_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== normalized_word_id_lookup.f =====
design/nwid_pkg.sv
design/nwid_front.sv
design/nwid_cmdq.sv
design/nwid_back.sv
design/normalized_word_id_lookup.sv
tb/sv/tb_normalized_word_id_lookup.sv
